// File: design/depth_preferred_transposition_table_unit_assert.svh
// Assertion macros shared by the transposition table RTL.
`ifndef DEPTH_PREFERRED_TRANSPOSITION_TABLE_UNIT_ASSERT_SVH
`define DEPTH_PREFERRED_TRANSPOSITION_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define DPTT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dptt assertion failed");
`define DPTT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dptt assertion failed");
`else
`define DPTT_ASSERT(lbl, prop)
`define DPTT_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: design/dptt_pkg.sv
// Types, codes and constants of the transposition table unit.
package dptt_pkg;

  localparam int ENTRIES_DEF   = 1024;
  localparam logic [3:0] NO_PIECE_CODE = 4'd6;

  localparam logic signed [7:0] RESET_DEPTH  = -8'sd100;
  localparam logic [7:0]        NONE_SQUARE  = 8'hFF;
  localparam logic [7:0]        DEFAULT_BITS = 8'hFF;

  localparam logic [1:0] SS_REAL      = 2'd0;
  localparam logic [1:0] SS_INVALID   = 2'd1;
  localparam logic [1:0] SS_SEARCHING = 2'd2;

  localparam logic [1:0] BK_NONE  = 2'd0;
  localparam logic [1:0] BK_ALPHA = 2'd1;
  localparam logic [1:0] BK_BETA  = 2'd2;
  localparam logic [1:0] BK_EXACT = 2'd3;

  typedef enum logic [2:0] {
    OP_PROBE       = 3'd0,
    OP_INSERT      = 3'd1,
    OP_RESET_MAIN  = 3'd2,
    OP_RESET_QUIET = 3'd3,
    OP_QPROBE      = 3'd4,
    OP_QINSERT     = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [63:0]        key;
    logic signed [7:0]  search_depth;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic [1:0]         bound_kind;
    logic [7:0]         from_square;
    logic [7:0]         to_square;
    logic [3:0]         from_piece;
    logic [3:0]         to_piece;
    logic [7:0]         move_bits;
    logic signed [15:0] move_score;
  } item_t;

  typedef struct packed {
    logic signed [7:0]  depth;
    logic [7:0]         fsq;
    logic [7:0]         tsq;
    logic [3:0]         fpc;
    logic [3:0]         tpc;
    logic [7:0]         bits;
    logic signed [15:0] score;
    logic [1:0]         sstate;
    logic [1:0]         bound;
  } rec_t;

  typedef struct packed {
    logic [63:0] key;
    rec_t        rec;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic               key_hit;
    logic [1:0]         score_state;
    logic signed [15:0] score;
    logic [7:0]         fsq;
    logic [7:0]         tsq;
    logic [3:0]         fpc;
    logic [3:0]         tpc;
    logic [7:0]         bits;
  } result_t;

  typedef struct packed {
    logic   main_we;
    entry_t main_data;
    logic   quiet_we;
    entry_t quiet_data;
  } wr_t;

  function automatic entry_t cleared_entry();
    entry_t e;
    e.key        = '1;
    e.rec.depth  = RESET_DEPTH;
    e.rec.fsq    = NONE_SQUARE;
    e.rec.tsq    = NONE_SQUARE;
    e.rec.fpc    = NO_PIECE_CODE;
    e.rec.tpc    = NO_PIECE_CODE;
    e.rec.bits   = DEFAULT_BITS;
    e.rec.score  = '0;
    e.rec.sstate = SS_INVALID;
    e.rec.bound  = BK_NONE;
    return e;
  endfunction

endpackage

// File: design/dptt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/dptt_index.sv
// Slot index unit: key modulo the entry count, masked or folded over three stages.
module dptt_index #(
  parameter int ENTRIES = dptt_pkg::ENTRIES_DEF,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  dptt_pkg::item_t  in_item,
  output logic             out_vld,
  output dptt_pkg::item_t  out_item,
  output logic [IDX_W-1:0] out_idx
);
  import dptt_pkg::*;

  localparam bit IDX_POW2 = ((ENTRIES & (ENTRIES - 1)) == 0);

  // 2^e mod ENTRIES for a non-power-of-two count, evaluated at elaboration
  function automatic logic [63:0] pow2_mod(input int e);
    logic [63:0] r;
    r = 64'd1;
    for (int i = 0; i < e; i++) begin
      r = r << 1;
      if (r >= 64'(ENTRIES)) begin
        r = r - 64'(ENTRIES);
      end
    end
    return r;
  endfunction

  if (IDX_POW2) begin : g_mask
    assign out_vld  = in_vld;
    assign out_item = in_item;
    assign out_idx  = IDX_W'(in_item.key % 64'(ENTRIES));
  end else begin : g_fold
    localparam int          NBYTE   = 8;
    localparam int          TW      = IDX_W + 8;
    localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / 64'(ENTRIES));
    localparam logic [31:0] MODULUS = 32'(ENTRIES);
    localparam logic [IDX_W:0] MOD_W = (IDX_W + 1)'(ENTRIES);

    logic [TW-1:0]  term [NBYTE];
    logic [31:0]    fold_sum;
    logic [63:0]    recip_prod;
    logic [31:0]    quot_prod;
    logic [31:0]    rem_full;

    logic           fa_vld;
    item_t          fa_item;
    logic [31:0]    fa_sum;
    logic           fb_vld;
    item_t          fb_item;
    logic [31:0]    fb_sum;
    logic [31:0]    fb_quot;
    logic           fc_vld;
    item_t          fc_item;
    logic [IDX_W:0] fc_rem;

    // each key byte weighted by its place value modulo the entry count
    for (genvar j = 0; j < NBYTE; j++) begin : g_term
      localparam logic [TW-1:0] RES = TW'(pow2_mod(8 * j));
      assign term[j] = TW'(in_item.key[8*j +: 8]) * RES;
    end

    always_comb begin
      fold_sum = '0;
      for (int j = 0; j < NBYTE; j++) begin
        fold_sum = fold_sum + 32'(term[j]);
      end
    end

    // reciprocal estimate is at most one below the true quotient
    assign recip_prod = 64'(fa_sum) * 64'(RECIP);
    assign quot_prod  = fb_quot * MODULUS;
    assign rem_full   = fb_sum - quot_prod;

    always_ff @(posedge clk) begin
      if (rst) begin
        fa_vld <= 1'b0;
        fb_vld <= 1'b0;
        fc_vld <= 1'b0;
      end else begin
        fa_vld <= in_vld;
        fb_vld <= fa_vld;
        fc_vld <= fb_vld;
      end
      fa_item <= in_item;
      fa_sum  <= fold_sum;
      fb_item <= fa_item;
      fb_sum  <= fa_sum;
      fb_quot <= recip_prod[63:32];
      fc_item <= fb_item;
      fc_rem  <= rem_full[IDX_W:0];
    end

    assign out_vld  = fc_vld;
    assign out_item = fc_item;
    assign out_idx  = (fc_rem >= MOD_W) ? IDX_W'(fc_rem - MOD_W) : fc_rem[IDX_W-1:0];
  end

endmodule

// File: design/dptt_core.sv
// Operation logic: probe answer, clamping and slot update for one transaction.
module dptt_core (
  input  dptt_pkg::item_t   item,
  input  dptt_pkg::entry_t  main_cur,
  input  dptt_pkg::entry_t  quiet_cur,
  output dptt_pkg::result_t res,
  output dptt_pkg::wr_t     wr
);
  import dptt_pkg::*;

  function automatic result_t with_move(input rec_t r, input logic [1:0] st);
    result_t o;
    o.key_hit     = 1'b1;
    o.score_state = st;
    o.score       = '0;
    o.fsq         = r.fsq;
    o.tsq         = r.tsq;
    o.fpc         = r.fpc;
    o.tpc         = r.tpc;
    o.bits        = r.bits;
    return o;
  endfunction

  function automatic result_t answer_hit(input rec_t r, input logic signed [15:0] a,
                                         input logic signed [15:0] b);
    result_t o;
    o = with_move(r, SS_INVALID);
    if (r.sstate != SS_REAL) begin
      o.score_state = r.sstate;
    end else if (r.bound == BK_ALPHA && $signed(r.score) <= a) begin
      o.score_state = SS_REAL;
      o.score       = a;
    end else if (r.bound == BK_BETA && $signed(r.score) >= b) begin
      o.score_state = SS_REAL;
      o.score       = b;
    end else if (r.bound == BK_EXACT) begin
      o.score_state = SS_REAL;
      o.score       = r.score;
    end
    return o;
  endfunction

  entry_t dflt;
  rec_t   ins_rec;
  logic   hit_m;
  logic   hit_q;
  logic   deep_m;
  logic   shallow_m;

  assign dflt      = cleared_entry();
  assign hit_m     = (main_cur.key == item.key);
  assign hit_q     = (quiet_cur.key == item.key);
  assign deep_m    = ($signed(main_cur.rec.depth) >= item.search_depth);
  assign shallow_m = ($signed(main_cur.rec.depth) < item.search_depth);

  always_comb begin
    ins_rec.depth  = item.search_depth;
    ins_rec.fsq    = item.from_square;
    ins_rec.tsq    = item.to_square;
    ins_rec.fpc    = item.from_piece;
    ins_rec.tpc    = item.to_piece;
    ins_rec.bits   = item.move_bits;
    ins_rec.score  = item.move_score;
    ins_rec.sstate = SS_REAL;
    ins_rec.bound  = item.bound_kind;
  end

  always_comb begin
    res = with_move(dflt.rec, SS_INVALID);
    res.key_hit   = 1'b0;
    wr.main_we    = 1'b0;
    wr.main_data  = main_cur;
    wr.quiet_we   = 1'b0;
    wr.quiet_data = quiet_cur;
    unique case (op_t'(item.op))
      OP_PROBE: begin
        if (hit_m && deep_m) begin
          res = answer_hit(main_cur.rec, item.alpha, item.beta);
        end else if (hit_m) begin
          res = with_move(main_cur.rec, SS_INVALID);
        end
        if (shallow_m) begin
          wr.main_we                = 1'b1;
          wr.main_data.key          = item.key;
          wr.main_data.rec.depth    = item.search_depth;
          wr.main_data.rec.sstate   = SS_SEARCHING;
        end
      end
      OP_INSERT: begin
        if ($signed(main_cur.rec.depth) <= item.search_depth) begin
          wr.main_we       = 1'b1;
          wr.main_data.key = item.key;
          wr.main_data.rec = ins_rec;
        end
      end
      OP_RESET_MAIN: begin
        if (hit_m) begin
          wr.main_we   = 1'b1;
          wr.main_data = dflt;
        end
      end
      OP_RESET_QUIET: begin
        if (hit_q) begin
          wr.quiet_we   = 1'b1;
          wr.quiet_data = dflt;
        end
      end
      OP_QPROBE: begin
        if (hit_q) begin
          res = answer_hit(quiet_cur.rec, item.alpha, item.beta);
        end else begin
          wr.quiet_we             = 1'b1;
          wr.quiet_data.key       = item.key;
          wr.quiet_data.rec.sstate = SS_SEARCHING;
        end
      end
      OP_QINSERT: begin
        wr.quiet_we            = 1'b1;
        wr.quiet_data.key      = item.key;
        wr.quiet_data.rec      = ins_rec;
        wr.quiet_data.rec.depth = quiet_cur.rec.depth;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: design/depth_preferred_transposition_table_unit.sv
// Top level of the depth-preferred transposition table unit.
//
//  channel   handshake         payload
//  --------  ----------------  ----------------------------------------------
//  command   start & !busy     op, key, search_depth, alpha, beta, bound_kind,
//                              from_square, to_square, from_piece, to_piece,
//                              move_bits, move_score
//  result    done (1 cycle)    key_hit, score_state, out_score, out_from_square,
//                              out_to_square, out_from_piece, out_to_piece,
//                              out_move_bits
//
// One transaction per cycle while busy is low. Each command gives exactly one
// result via the s1 and res_q registers, plus the fa, fb and fc registers of
// the folded slot index when ENTRIES is not a power of two. The table RAM is
// read at the slot index and written from s1; a write is forwarded to the next
// command on the same slot. After reset busy stays high while both tables are
// cleared. Results cannot be stalled: done is high for one cycle per result.
`include "depth_preferred_transposition_table_unit_assert.svh"

module depth_preferred_transposition_table_unit #(
  parameter int ENTRIES = dptt_pkg::ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         op,
  input  logic [63:0]        key,
  input  logic signed [7:0]  search_depth,
  input  logic signed [15:0] alpha,
  input  logic signed [15:0] beta,
  input  logic [1:0]         bound_kind,
  input  logic [7:0]         from_square,
  input  logic [7:0]         to_square,
  input  logic [3:0]         from_piece,
  input  logic [3:0]         to_piece,
  input  logic [7:0]         move_bits,
  input  logic signed [15:0] move_score,
  output logic               done,
  output logic               key_hit,
  output logic [1:0]         score_state,
  output logic signed [15:0] out_score,
  output logic [7:0]         out_from_square,
  output logic [7:0]         out_to_square,
  output logic [3:0]         out_from_piece,
  output logic [3:0]         out_to_piece,
  output logic [7:0]         out_move_bits
);
  import dptt_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  item_t            in_item;
  logic             accept;
  logic             ix_vld;
  item_t            ix_item;
  logic [IDX_W-1:0] ix_idx;

  logic             s1_vld;
  item_t            s1_item;
  logic [IDX_W-1:0] s1_idx;

  logic [IDX_W-1:0] clr_addr;

  logic [ENTRY_W-1:0] main_rdata;
  logic [ENTRY_W-1:0] quiet_rdata;
  entry_t             main_cur;
  entry_t             quiet_cur;

  logic             fwd_main_vld;
  logic [IDX_W-1:0] fwd_main_idx;
  entry_t           fwd_main_data;
  logic             fwd_quiet_vld;
  logic [IDX_W-1:0] fwd_quiet_idx;
  entry_t           fwd_quiet_data;

  result_t res;
  result_t res_q;
  wr_t     wr;

  logic               main_we;
  logic [IDX_W-1:0]   main_waddr;
  logic [ENTRY_W-1:0] main_wdata;
  logic               quiet_we;
  logic [IDX_W-1:0]   quiet_waddr;
  logic [ENTRY_W-1:0] quiet_wdata;

  assign accept = start & ~busy;

  always_comb begin
    in_item.op           = op;
    in_item.key          = key;
    in_item.search_depth = search_depth;
    in_item.alpha        = alpha;
    in_item.beta         = beta;
    in_item.bound_kind   = bound_kind;
    in_item.from_square  = from_square;
    in_item.to_square    = to_square;
    in_item.from_piece   = from_piece;
    in_item.to_piece     = to_piece;
    in_item.move_bits    = move_bits;
    in_item.move_score   = move_score;
  end

  dptt_index #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_index (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (accept),
    .in_item  (in_item),
    .out_vld  (ix_vld),
    .out_item (ix_item),
    .out_idx  (ix_idx)
  );

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == IDX_W'(ENTRIES - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= ix_vld;
    end
    s1_item <= ix_item;
    s1_idx  <= ix_idx;
  end

  assign main_cur  = (fwd_main_vld && fwd_main_idx == s1_idx) ?
                     fwd_main_data : entry_t'(main_rdata);
  assign quiet_cur = (fwd_quiet_vld && fwd_quiet_idx == s1_idx) ?
                     fwd_quiet_data : entry_t'(quiet_rdata);

  dptt_core u_core (
    .item      (s1_item),
    .main_cur  (main_cur),
    .quiet_cur (quiet_cur),
    .res       (res),
    .wr        (wr)
  );

  assign main_we     = busy | (s1_vld & wr.main_we);
  assign main_waddr  = busy ? clr_addr : s1_idx;
  assign main_wdata  = busy ? cleared_entry() : wr.main_data;
  assign quiet_we    = busy | (s1_vld & wr.quiet_we);
  assign quiet_waddr = busy ? clr_addr : s1_idx;
  assign quiet_wdata = busy ? cleared_entry() : wr.quiet_data;

  dptt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_main_ram (
    .clk   (clk),
    .we    (main_we),
    .waddr (main_waddr),
    .wdata (main_wdata),
    .raddr (ix_idx),
    .rdata (main_rdata)
  );

  dptt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_quiet_ram (
    .clk   (clk),
    .we    (quiet_we),
    .waddr (quiet_waddr),
    .wdata (quiet_wdata),
    .raddr (ix_idx),
    .rdata (quiet_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_main_vld  <= 1'b0;
      fwd_quiet_vld <= 1'b0;
    end else begin
      fwd_main_vld  <= s1_vld & wr.main_we;
      fwd_quiet_vld <= s1_vld & wr.quiet_we;
    end
    fwd_main_idx   <= s1_idx;
    fwd_main_data  <= wr.main_data;
    fwd_quiet_idx  <= s1_idx;
    fwd_quiet_data <= wr.quiet_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_vld;
    end
    res_q <= res;
  end

  assign key_hit         = res_q.key_hit;
  assign score_state     = res_q.score_state;
  assign out_score       = res_q.score;
  assign out_from_square = res_q.fsq;
  assign out_to_square   = res_q.tsq;
  assign out_from_piece  = res_q.fpc;
  assign out_to_piece    = res_q.tpc;
  assign out_move_bits   = res_q.bits;

  `DPTT_ASSERT(a_idle_while_clearing, busy |-> !s1_vld && !done)
  `DPTT_ASSERT(a_clear_once, !busy |=> !busy)
  `DPTT_ASSERT(a_one_table_written, !(fwd_main_vld && fwd_quiet_vld))
  `DPTT_ASSERT(a_score_zero_unless_real, done && score_state != SS_REAL |-> out_score == 16'sd0)
  `DPTT_ASSERT_ALWAYS(a_reset_idle, rst |=> busy && !done)

endmodule
